// ===== rtl/sta38_pkg.sv =====
// ----------------------------------------------------------------------------
// sta38_pkg
// Shared constants and types for the Simpson 3/8 streaming integrator.
// ----------------------------------------------------------------------------
package sta38_pkg;

	localparam int MAX_SAMPLES  = 65536;
	localparam int SAMPLE_WIDTH = 32;

	// Port widths of the sample and result words.
	localparam int IN_WIDTH  = 32;
	localparam int OUT_WIDTH = 52;

	// Internal widths: open panel partial sum, running total, sample counter.
	localparam int PART_WIDTH  = SAMPLE_WIDTH + 3;
	localparam int TOTAL_WIDTH = 54;
	localparam int CNT_WIDTH   = $clog2(MAX_SAMPLES + 1);

	// Number of samples held in the open panel; zero means run start.
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_ONE   = 2'd1;
	localparam logic [1:0] PH_TWO   = 2'd2;
	localparam logic [1:0] PH_THREE = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] panel_start;
		logic signed [SAMPLE_WIDTH-1:0] first_inner;
		logic signed [PART_WIDTH-1:0]   panel_partial;
		logic [1:0]                     panel_phase;
		logic [CNT_WIDTH-1:0]           sample_count;
		logic signed [TOTAL_WIDTH-1:0]  running_total;
		logic                           overflow_seen;
	} sta38_state_t;

endpackage

// ===== rtl/sta38_if.sv =====
// ----------------------------------------------------------------------------
// sta38_sample_if / sta38_result_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface sta38_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sta38_pkg::IN_WIDTH-1:0] sample;
	logic                                 last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface sta38_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sta38_pkg::OUT_WIDTH-1:0] integral_x8;
	logic                                  too_long;

	modport source (output valid, output integral_x8, output too_long, input ready);
	modport sink (input valid, input integral_x8, input too_long, output ready);
endinterface

// ===== rtl/sta38_step.sv =====
// ----------------------------------------------------------------------------
// sta38_step
// Next-state and result logic for one sample of the integrator.
// ----------------------------------------------------------------------------
module sta38_step (
	input  sta38_pkg::sta38_state_t                st,
	input  logic signed [sta38_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                   last,
	output sta38_pkg::sta38_state_t                st_next,
	output logic signed [sta38_pkg::OUT_WIDTH-1:0]  integral_x8,
	output logic                                   too_long
);
	import sta38_pkg::*;

	localparam int TW = TOTAL_WIDTH;
	localparam int SW = SAMPLE_WIDTH;
	localparam int PW = PART_WIDTH;

	logic                 take;
	logic signed [TW-1:0] s_w, a_w, b_w, p_w;
	logic signed [TW-1:0] held_two, held_three, with_one, with_two, with_three;
	logic signed [TW-1:0] ps_w, result;
	logic signed [PW-1:0] a_p, b_p, s_p, bs_p;

	always_comb begin
		take = st.sample_count < CNT_WIDTH'(MAX_SAMPLES);

		s_w = {{(TW-SW){sample[SW-1]}}, sample};
		a_w = {{(TW-SW){st.panel_start[SW-1]}}, st.panel_start};
		b_w = {{(TW-SW){st.first_inner[SW-1]}}, st.first_inner};
		p_w = {{(TW-PW){st.panel_partial[PW-1]}}, st.panel_partial};

		// Trapezoid tails and panel closures, all scaled by eight.
		held_two   = (a_w + b_w) <<< 2;
		held_three = (p_w - a_w - (b_w <<< 1)) <<< 2;
		with_one   = (a_w + s_w) <<< 2;
		with_two   = (a_w + (b_w <<< 1) + s_w) <<< 2;
		ps_w       = p_w + s_w;
		with_three = ps_w + (ps_w <<< 1);

		a_p  = {{(PW-SW){st.panel_start[SW-1]}}, st.panel_start};
		b_p  = {{(PW-SW){st.first_inner[SW-1]}}, st.first_inner};
		s_p  = {{(PW-SW){sample[SW-1]}}, sample};
		bs_p = b_p + s_p;

		result = st.running_total;
		if (take) begin
			case (st.panel_phase)
				PH_ONE:   result = st.running_total + with_one;
				PH_TWO:   result = st.running_total + with_two;
				PH_THREE: result = st.running_total + with_three;
				default:  result = st.running_total;
			endcase
		end else begin
			case (st.panel_phase)
				PH_TWO:   result = st.running_total + held_two;
				PH_THREE: result = st.running_total + held_three;
				default:  result = st.running_total;
			endcase
		end

		integral_x8 = result[OUT_WIDTH-1:0];
		too_long    = st.overflow_seen | ~take;

		st_next = st;
		st_next.overflow_seen = st.overflow_seen | ~take;
		if (last) begin
			st_next = '0;
		end else if (take) begin
			st_next.sample_count = st.sample_count + 1'b1;
			case (st.panel_phase)
				PH_START: begin
					st_next.panel_start = sample;
					st_next.panel_phase = PH_ONE;
				end
				PH_ONE: begin
					st_next.first_inner = sample;
					st_next.panel_phase = PH_TWO;
				end
				PH_TWO: begin
					// In phase three the pair shifts down to hold f1 and f2.
					st_next.panel_partial = a_p + bs_p + (bs_p <<< 1);
					st_next.panel_start   = st.first_inner;
					st_next.first_inner   = sample;
					st_next.panel_phase   = PH_THREE;
				end
				default: begin
					st_next.running_total = st.running_total + with_three;
					st_next.panel_start   = sample;
					st_next.panel_phase   = PH_ONE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/simpson_three_eighths_accumulator.sv =====
// ----------------------------------------------------------------------------
// simpson_three_eighths_accumulator
// Streaming composite Simpson 3/8 integrator with a trapezoid tail, scaled by 8.
// ----------------------------------------------------------------------------
// Path: a run's last sample is held in the input register, then its result word
// in the result register. Throughput: one sample word per cycle; the input register and the result
// register are the only stages, and only a last word waits while an earlier
// result word is still unread.
// Reset: arst_n clears the run state and the pipeline valid bits.
module simpson_three_eighths_accumulator (
	input logic            clk,
	input logic            arst_n,
	sta38_sample_if.sink   samples,
	sta38_result_if.source results
);
	import sta38_pkg::*;

	logic                         valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                         last_s1;

	logic                         valid_s2;
	logic signed [OUT_WIDTH-1:0]  integral_s2;
	logic                         too_long_s2;

	sta38_state_t                 state_q;
	sta38_state_t                 state_next;
	logic signed [OUT_WIDTH-1:0]  step_integral;
	logic                         step_too_long;

	logic out_free;
	logic advance;

	// Only a last word needs room in the result register; other words pass freely.
	assign out_free      = ~valid_s2 | results.ready;
	assign advance       = valid_s1 & (~last_s1 | out_free);
	assign samples.ready = ~valid_s1 | ~last_s1 | out_free;

	sta38_step u_step (
		.st          (state_q),
		.sample      (sample_s1),
		.last        (last_s1),
		.st_next     (state_next),
		.integral_x8 (step_integral),
		.too_long    (step_too_long)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample[SAMPLE_WIDTH-1:0];
			last_s1   <= samples.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// A result word is loaded only for a last sample; other samples do not load it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			integral_s2 <= step_integral;
			too_long_s2 <= step_too_long;
		end
	end

	assign results.valid       = valid_s2;
	assign results.integral_x8 = integral_s2;
	assign results.too_long    = too_long_s2;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Simpson 3/8 integrator. A short table of runs
// covers the sample extremes and every panel ending. Random runs follow under
// three back-pressure settings, and three runs sit at the sample limit. Every
// result word is checked against a typed table value or an in-bench integrator.
// ----------------------------------------------------------------------------
module tb_top;

	import sta38_pkg::*;

	localparam logic [63:0] TOTAL_MASK = (64'd1 << TOTAL_WIDTH) - 64'd1;
	localparam logic [IN_WIDTH-1:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [IN_WIDTH-1:0] S_MIN = 32'h8000_0000;
	localparam logic [IN_WIDTH-1:0] S_NEG1 = 32'hFFFF_FFFF;
	localparam int DRAIN_CYCLES = 8;
	localparam int N_DIRECTED = 22;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] integral_x8;
		logic                        too_long;
	} result_word_t;

	typedef struct packed {
		logic [IN_WIDTH-1:0]         sample;
		logic                        last;
		logic                        typed;
		logic signed [OUT_WIDTH-1:0] integral_x8;
		logic                        too_long;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sta38_sample_if samples ();
	sta38_result_if results ();

	simpson_three_eighths_accumulator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// Integrator state of the open run.
	logic [63:0] held_f0;
	logic [63:0] held_f1;
	logic [63:0] held_partial;
	logic [1:0]  held_phase;
	int unsigned run_count;
	logic [63:0] run_total;
	logic        run_dropped;

	result_word_t pending_integrals[$];
	int mismatch_count = 0;
	int src_idle_pct;
	int snk_stall_pct;

	// Runs of one to seven samples; a typed value is what the rule gives by hand.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{32'h0,  1'b1, 1'b1, 52'sd0, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b1, 1'b1, 52'sd17179869176, 1'b0},
		'{S_MIN,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MIN,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MIN,  1'b1, 1'b1, -52'sd34359738368, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b1, 1'b1, 52'sd51539607528, 1'b0},
		'{32'd1,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_NEG1, 1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MIN,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{32'd5,  1'b1, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MIN,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{32'h0,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_NEG1, 1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MAX,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{S_MIN,  1'b0, 1'b0, 52'sd0, 1'b0},
		'{32'd123, 1'b1, 1'b0, 52'sd0, 1'b0}
	};

	function automatic void clear_run();
		held_f0 = '0;
		held_f1 = '0;
		held_partial = '0;
		held_phase = PH_START;
		run_count = 0;
		run_total = '0;
		run_dropped = 1'b0;
	endfunction

	// Feeds one accepted sample word into the integrator; a last word closes the run.
	function automatic void integrate_sample(input logic [IN_WIDTH-1:0] raw,
			input logic is_last, output bit produced, output result_word_t word);
		logic [63:0] s;
		logic [63:0] t;
		bit take;
		s = {{(64-SAMPLE_WIDTH){raw[SAMPLE_WIDTH-1]}}, raw[SAMPLE_WIDTH-1:0]};
		take = run_count < MAX_SAMPLES;
		produced = 1'b0;
		word = '0;
		if (!take)
			run_dropped = 1'b1;
		if (!is_last) begin
			if (take) begin
				case (held_phase)
					PH_START: begin
						held_f0 = s;
						held_phase = PH_ONE;
					end
					PH_ONE: begin
						held_f1 = s;
						held_phase = PH_TWO;
					end
					PH_TWO: begin
						held_partial = held_f0 + 64'd3 * (held_f1 + s);
						held_f0 = held_f1;
						held_f1 = s;
						held_phase = PH_THREE;
					end
					default: begin
						run_total = (run_total + 64'd3 * (held_partial + s)) & TOTAL_MASK;
						held_f0 = s;
						held_phase = PH_ONE;
					end
				endcase
				run_count++;
			end
			return;
		end
		t = run_total;
		if (take) begin
			case (held_phase)
				PH_ONE:   t += 64'd4 * (held_f0 + s);
				PH_TWO:   t += 64'd4 * (held_f0 + 64'd2 * held_f1 + s);
				PH_THREE: t += 64'd3 * (held_partial + s);
				default:  ;
			endcase
		end else begin
			// The dropped last word closes the run on the samples still held.
			case (held_phase)
				PH_TWO:   t += 64'd4 * (held_f0 + held_f1);
				PH_THREE: t += 64'd4 * (held_partial - held_f0 - 64'd2 * held_f1);
				default:  ;
			endcase
		end
		word.integral_x8 = t[OUT_WIDTH-1:0];
		word.too_long = run_dropped;
		produced = 1'b1;
		clear_run();
	endfunction

	function automatic logic [IN_WIDTH-1:0] random_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return S_NEG1;
			3: return IN_WIDTH'($urandom_range(20)) - IN_WIDTH'(10);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [IN_WIDTH-1:0] s, input logic l,
			input bit typed = 1'b0, input result_word_t typed_word = '0);
		bit produced;
		result_word_t word;
		while ($urandom_range(99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample <= s;
		samples.last <= l;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		integrate_sample(s, l, produced, word);
		if (produced)
			pending_integrals.push_back(typed ? typed_word : word);
	endtask

	// Holds the input quiet until every expected word has come out.
	task automatic wait_idle();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (pending_integrals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int src_pct, input int snk_pct, input int n_words);
		int sent;
		int len;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		sent = 0;
		while (sent < n_words) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			for (int i = 0; i < len; i++)
				send_word(random_sample(), i == len - 1);
			sent += len;
		end
	endtask

	task automatic long_run(input int n_body);
		for (int i = 0; i < n_body; i++)
			send_word($urandom, 1'b0);
		send_word(random_sample(), 1'b1);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (pending_integrals.size() == 0) begin
					$display("%0t: unexpected result word, integral_x8 %0d too_long %0b",
						$time, results.integral_x8, results.too_long);
					mismatch_count++;
				end else begin
					result_word_t exp_word;
					exp_word = pending_integrals.pop_front();
					if (results.integral_x8 !== exp_word.integral_x8) begin
						$display("%0t: integral_x8 expected %0d, got %0d",
							$time, exp_word.integral_x8, results.integral_x8);
						mismatch_count++;
					end
					if (results.too_long !== exp_word.too_long) begin
						$display("%0t: too_long expected %0b, got %0b",
							$time, exp_word.too_long, results.too_long);
						mismatch_count++;
					end
				end
			end
			results.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.sample = '0;
		samples.last = 1'b0;
		results.ready = 1'b0;
		src_idle_pct = 19;
		snk_stall_pct = 54;
		clear_run();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i].sample, directed_rows[i].last, directed_rows[i].typed,
				'{directed_rows[i].integral_x8, directed_rows[i].too_long});
		wait_idle();

		random_phase(19, 54, 200);
		wait_idle();
		random_phase(54, 19, 200);
		wait_idle();

		// Runs at the sample limit: the last word fits, is dropped, or comes late.
		src_idle_pct = 0;
		snk_stall_pct = 0;
		long_run(MAX_SAMPLES - 1);
		long_run(MAX_SAMPLES);
		long_run(MAX_SAMPLES + 2);
		random_phase(0, 0, 200);
		wait_idle();

		if (mismatch_count == 0 && pending_integrals.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
